// ===== design/beam_direction_cosines_top_defines.svh =====
// Assertion macros for the beam direction cosine block.
// Used by beam_direction_cosines_top; no other dependencies.
`ifndef BEAM_DIRECTION_COSINES_TOP_DEFINES_SVH
`define BEAM_DIRECTION_COSINES_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BDC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BDC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BDC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define BDC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/bdc_pkg.sv =====
// Shared types and constants for the beam direction cosine block.
// No dependencies.
package bdc_pkg;

    localparam int COORD_WIDTH_DEF   = 32;
    localparam int COS_FRAC_BITS_DEF = 14;
    localparam int OUT_W             = 16;
    localparam int MAG_W             = 30;   // normalized magnitude width
    localparam int MAG_TOP           = 29;   // target position of the leading one
    localparam int ROOT_W            = 31;   // bits of floor(sqrt(sum of squares))

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] end_z;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] axis_x_0;
        logic signed [15:0] axis_x_1;
        logic signed [15:0] axis_x_2;
        logic signed [15:0] axis_y_0;
        logic signed [15:0] axis_y_1;
        logic signed [15:0] axis_y_2;
        logic signed [15:0] axis_z_0;
        logic signed [15:0] axis_z_1;
        logic signed [15:0] axis_z_2;
        logic               degenerate;
    } out_word_t;

    // abs, encode, shift, square, sum, root bits, numerator, quotient bits, sign
    function automatic int unit_latency(input int frac);
        return frac + 39;
    endfunction

endpackage

// ===== design/bdc_unit_vec.sv =====
// Pipelined normalizer: three signed components to a Q1.F unit vector.
// Depends on bdc_pkg. One word per cycle while en is high; en low freezes every stage.
module bdc_unit_vec #(
    parameter int W = 33,
    parameter int F = 14
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [3*W-1:0]       vec,
    output logic                 out_valid,
    output logic                 zero,
    output logic [3*(F+2)-1:0]   cos
);
    import bdc_pkg::*;

    localparam int MW    = (W > MAG_W) ? W : MAG_W;
    localparam int AW    = $clog2(MW) + 1;
    localparam int REM_W = 2 * ROOT_W + 1;
    localparam int NW    = MAG_W + F + 2;
    localparam int DS    = F + 1;
    localparam int CSW   = F + 2;

    // stage 1: magnitudes
    logic         v1_reg;
    logic [W-1:0] mag1_reg [0:2];
    logic [2:0]   neg1_reg;
    // stage 2: leading-one encode
    logic         v2_reg, zero2_reg, right2_reg;
    logic [AW-1:0] amt2_reg;
    logic [W-1:0] mag2_reg [0:2];
    logic [2:0]   neg2_reg;
    // stage 3: shifted
    logic         v3_reg, zero3_reg;
    logic [MAG_W-1:0] m3_reg [0:2];
    logic [2:0]   neg3_reg;
    // stage 4: squares
    logic         v4_reg, zero4_reg;
    logic [MAG_W-1:0]   m4_reg [0:2];
    logic [2*MAG_W-1:0] sq4_reg [0:2];
    logic [2:0]   neg4_reg;
    // root stages
    logic              sv_reg    [0:ROOT_W];
    logic              szero_reg [0:ROOT_W];
    logic [REM_W-1:0]  srem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0] sroot_reg [0:ROOT_W];
    logic [MAG_W-1:0]  sm_reg    [0:ROOT_W][0:2];
    logic [2:0]        sneg_reg  [0:ROOT_W];
    // divide stages
    logic              dv_reg    [0:DS];
    logic              dzero_reg [0:DS];
    logic [ROOT_W-1:0] dlen_reg  [0:DS];
    logic [NW-1:0]     drem_reg  [0:DS][0:2];
    logic [F:0]        dq_reg    [0:DS][0:2];
    logic [2:0]        dneg_reg  [0:DS];
    // output
    logic              ov_reg, ozero_reg;
    logic [3*CSW-1:0]  ocos_reg;

    logic [W-1:0]      mag1_next [0:2];
    logic [2:0]        neg1_next;
    logic [W-1:0]      orv;
    logic [AW-1:0]     pos;
    logic [AW-1:0]     amt2_next;
    logic [MAG_W-1:0]  m3_next [0:2];
    logic [REM_W-1:0]  srem_next  [0:ROOT_W-1];
    logic [ROOT_W-1:0] sroot_next [0:ROOT_W-1];
    logic [NW-1:0]     drem_next  [0:DS-1][0:2];
    logic [F:0]        dq_next    [0:DS-1][0:2];
    logic [3*CSW-1:0]  ocos_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg1_next[i] = vec[i*W + W - 1];
            mag1_next[i] = neg1_next[i] ? (~vec[i*W +: W] + W'(1)) : vec[i*W +: W];
        end
    end

    always_comb
    begin
        orv = mag1_reg[0] | mag1_reg[1] | mag1_reg[2];
        pos = '0;
        for (int b = 0; b < W; b++)
        begin
            if (orv[b])
                pos = AW'(b);
        end
        amt2_next = (pos > AW'(MAG_TOP)) ? (pos - AW'(MAG_TOP)) : (AW'(MAG_TOP) - pos);
    end

    always_comb
    begin
        logic [MW-1:0] ext;
        logic [MW-1:0] sh;
        for (int i = 0; i < 3; i++)
        begin
            ext = MW'(mag2_reg[i]);
            sh  = right2_reg ? (ext >> amt2_reg) : (ext << amt2_reg);
            m3_next[i] = sh[MAG_W-1:0];
        end
    end

    // one root bit per stage, most significant first
    always_comb
    begin
        logic [REM_W-1:0] cand;
        for (int j = 0; j < ROOT_W; j++)
        begin
            cand = (REM_W'(sroot_reg[j]) << (ROOT_W - j))
                 + (REM_W'(1) << (2 * (ROOT_W - 1 - j)));
            if (srem_reg[j] >= cand)
            begin
                srem_next[j]  = srem_reg[j] - cand;
                sroot_next[j] = sroot_reg[j] | (ROOT_W'(1) << (ROOT_W - 1 - j));
            end
            else
            begin
                srem_next[j]  = srem_reg[j];
                sroot_next[j] = sroot_reg[j];
            end
        end
    end

    // one quotient bit per stage, three components share the divisor
    always_comb
    begin
        logic [NW-1:0] dsr;
        for (int k = 0; k < DS; k++)
        begin
            dsr = NW'(dlen_reg[k]) << (F - k);
            for (int i = 0; i < 3; i++)
            begin
                if (drem_reg[k][i] >= dsr)
                begin
                    drem_next[k][i] = drem_reg[k][i] - dsr;
                    dq_next[k][i]   = dq_reg[k][i] | ((F+1)'(1) << (F - k));
                end
                else
                begin
                    drem_next[k][i] = drem_reg[k][i];
                    dq_next[k][i]   = dq_reg[k][i];
                end
            end
        end
    end

    always_comb
    begin
        logic [CSW-1:0] q;
        for (int i = 0; i < 3; i++)
        begin
            q = CSW'(dq_reg[DS][i]);
            if (dzero_reg[DS])
                ocos_next[i*CSW +: CSW] = '0;
            else if (dneg_reg[DS][i])
                ocos_next[i*CSW +: CSW] = ~q + CSW'(1);
            else
                ocos_next[i*CSW +: CSW] = q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            ov_reg <= 1'b0;
            for (int j = 0; j <= ROOT_W; j++)
                sv_reg[j] <= 1'b0;
            for (int k = 0; k <= DS; k++)
                dv_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            sv_reg[0] <= v4_reg;
            for (int j = 0; j < ROOT_W; j++)
                sv_reg[j+1] <= sv_reg[j];
            dv_reg[0] <= sv_reg[ROOT_W];
            for (int k = 0; k < DS; k++)
                dv_reg[k+1] <= dv_reg[k];
            ov_reg <= dv_reg[DS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg   <= neg1_next;
            neg2_reg   <= neg1_reg;
            zero2_reg  <= (orv == '0);
            right2_reg <= (pos > AW'(MAG_TOP));
            amt2_reg   <= amt2_next;
            neg3_reg   <= neg2_reg;
            zero3_reg  <= zero2_reg;
            neg4_reg   <= neg3_reg;
            zero4_reg  <= zero3_reg;
            for (int i = 0; i < 3; i++)
            begin
                mag1_reg[i] <= mag1_next[i];
                mag2_reg[i] <= mag1_reg[i];
                m3_reg[i]   <= m3_next[i];
                m4_reg[i]   <= m3_reg[i];
                sq4_reg[i]  <= m3_reg[i] * m3_reg[i];
                sm_reg[0][i] <= m4_reg[i];
            end
            srem_reg[0]  <= REM_W'(sq4_reg[0]) + REM_W'(sq4_reg[1]) + REM_W'(sq4_reg[2]);
            sroot_reg[0] <= '0;
            sneg_reg[0]  <= neg4_reg;
            szero_reg[0] <= zero4_reg;
            for (int j = 0; j < ROOT_W; j++)
            begin
                srem_reg[j+1]  <= srem_next[j];
                sroot_reg[j+1] <= sroot_next[j];
                sneg_reg[j+1]  <= sneg_reg[j];
                szero_reg[j+1] <= szero_reg[j];
                for (int i = 0; i < 3; i++)
                    sm_reg[j+1][i] <= sm_reg[j][i];
            end
            dlen_reg[0]  <= sroot_reg[ROOT_W];
            dneg_reg[0]  <= sneg_reg[ROOT_W];
            dzero_reg[0] <= szero_reg[ROOT_W];
            for (int i = 0; i < 3; i++)
            begin
                drem_reg[0][i] <= (NW'(sm_reg[ROOT_W][i]) << F)
                                + NW'(sroot_reg[ROOT_W] >> 1);
                dq_reg[0][i]   <= '0;
            end
            for (int k = 0; k < DS; k++)
            begin
                dlen_reg[k+1]  <= dlen_reg[k];
                dneg_reg[k+1]  <= dneg_reg[k];
                dzero_reg[k+1] <= dzero_reg[k];
                for (int i = 0; i < 3; i++)
                begin
                    drem_reg[k+1][i] <= drem_next[k][i];
                    dq_reg[k+1][i]   <= dq_next[k][i];
                end
            end
            ozero_reg <= dzero_reg[DS];
            ocos_reg  <= ocos_next;
        end
    end

    assign out_valid = ov_reg;
    assign zero      = ozero_reg;
    assign cos       = ocos_reg;

endmodule

// ===== design/beam_direction_cosines_top.sv =====
// Beam direction cosines: throughput one word per cycle while the output is not stalled;
// depth is set by the two chained normalizers, mainly by their square-root and
// quotient stages.
// A stalled output freezes the whole pipeline; input ready follows the output slot.
// rst_n asynchronously clears all valid bits; data registers are not reset.
`include "beam_direction_cosines_top_defines.svh"
module beam_direction_cosines_top #(
    parameter int COORD_WIDTH   = bdc_pkg::COORD_WIDTH_DEF,
    parameter int COS_FRAC_BITS = bdc_pkg::COS_FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bdc_pkg::in_word_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output bdc_pkg::out_word_t out_data
);
    import bdc_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int F   = COS_FRAC_BITS;
    localparam int XW  = CW + 1;
    localparam int CSW = F + 2;
    localparam int PW  = 2 * CSW;
    localparam int ZW  = PW + 1;
    localparam int UL  = unit_latency(F);
    localparam int DLY = UL + 2;
    localparam int DW  = 6 * CSW + 1;

    logic adv;
    logic out_valid_reg;
    out_word_t out_data_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // input stage: axis difference and normal
    logic          v0_reg;
    logic [3*XW-1:0] dvec_reg;
    logic [3*CW-1:0] nvec_reg;
    logic signed [XW-1:0] d_next [0:2];
    logic signed [CW-1:0] cs [0:2];
    logic signed [CW-1:0] ce [0:2];
    logic signed [CW-1:0] cn [0:2];

    always_comb
    begin
        cs[0] = CW'($unsigned(in_data.start_x));
        cs[1] = CW'($unsigned(in_data.start_y));
        cs[2] = CW'($unsigned(in_data.start_z));
        ce[0] = CW'($unsigned(in_data.end_x));
        ce[1] = CW'($unsigned(in_data.end_y));
        ce[2] = CW'($unsigned(in_data.end_z));
        cn[0] = CW'($unsigned(in_data.normal_x));
        cn[1] = CW'($unsigned(in_data.normal_y));
        cn[2] = CW'($unsigned(in_data.normal_z));
        for (int i = 0; i < 3; i++)
            d_next[i] = XW'(ce[i]) - XW'(cs[i]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dvec_reg[i*XW +: XW] <= d_next[i];
                nvec_reg[i*CW +: CW] <= cn[i];
            end
        end
    end

    logic x_valid, x_zero, y_valid, y_zero, z_valid, z_zero;
    logic [3*CSW-1:0] x_cos, y_cos, z_cos;

    bdc_unit_vec #(.W(XW), .F(F)) u_axis_x (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v0_reg), .vec(dvec_reg),
        .out_valid(x_valid), .zero(x_zero), .cos(x_cos)
    );

    bdc_unit_vec #(.W(CW), .F(F)) u_axis_y (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v0_reg), .vec(nvec_reg),
        .out_valid(y_valid), .zero(y_zero), .cos(y_cos)
    );

    // cross product: products, then differences
    logic          c1_valid_reg, c2_valid_reg;
    logic signed [PW-1:0] prod_reg [0:5];
    logic [3*ZW-1:0] cvec_reg;
    logic signed [CSW-1:0] ax [0:2];
    logic signed [CSW-1:0] ay [0:2];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ax[i] = $signed(x_cos[i*CSW +: CSW]);
            ay[i] = $signed(y_cos[i*CSW +: CSW]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg[0] <= ax[1] * ay[2];
            prod_reg[1] <= ax[2] * ay[1];
            prod_reg[2] <= ax[2] * ay[0];
            prod_reg[3] <= ax[0] * ay[2];
            prod_reg[4] <= ax[0] * ay[1];
            prod_reg[5] <= ax[1] * ay[0];
            for (int i = 0; i < 3; i++)
                cvec_reg[i*ZW +: ZW] <= ZW'(prod_reg[2*i]) - ZW'(prod_reg[2*i+1]);
        end
    end

    bdc_unit_vec #(.W(ZW), .F(F)) u_axis_z (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(c2_valid_reg), .vec(cvec_reg),
        .out_valid(z_valid), .zero(z_zero), .cos(z_cos)
    );

    // x and y results wait alongside the z normalizer
    logic [DW-1:0] dl_reg [0:DLY-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dl_reg[0] <= {x_cos, y_cos, x_zero | y_zero};
            for (int k = 1; k < DLY; k++)
                dl_reg[k] <= dl_reg[k-1];
        end
    end

    logic [3*CSW-1:0] dx_cos, dy_cos;
    logic             dxy_zero;
    out_word_t        out_next;

    assign dx_cos   = dl_reg[DLY-1][DW-1 -: 3*CSW];
    assign dy_cos   = dl_reg[DLY-1][3*CSW -: 3*CSW];
    assign dxy_zero = dl_reg[DLY-1][0];

    always_comb
    begin
        out_next.axis_x_0   = OUT_W'($signed(dx_cos[0*CSW +: CSW]));
        out_next.axis_x_1   = OUT_W'($signed(dx_cos[1*CSW +: CSW]));
        out_next.axis_x_2   = OUT_W'($signed(dx_cos[2*CSW +: CSW]));
        out_next.axis_y_0   = OUT_W'($signed(dy_cos[0*CSW +: CSW]));
        out_next.axis_y_1   = OUT_W'($signed(dy_cos[1*CSW +: CSW]));
        out_next.axis_y_2   = OUT_W'($signed(dy_cos[2*CSW +: CSW]));
        out_next.axis_z_0   = OUT_W'($signed(z_cos[0*CSW +: CSW]));
        out_next.axis_z_1   = OUT_W'($signed(z_cos[1*CSW +: CSW]));
        out_next.axis_z_2   = OUT_W'($signed(z_cos[2*CSW +: CSW]));
        out_next.degenerate = dxy_zero | z_zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            c1_valid_reg  <= 1'b0;
            c2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg        <= in_valid;
            c1_valid_reg  <= x_valid;
            c2_valid_reg  <= c1_valid_reg;
            out_valid_reg <= z_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_data_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `BDC_ASSERT_IMP(a_xy_aligned, clk, rst_n, 1'b1, x_valid == y_valid, "x/y normalizers out of step")
    `BDC_ASSERT_IMP(a_x_zero, clk, rst_n, x_valid && x_zero, x_cos == '0, "zero x axis with nonzero cosines")
    `BDC_ASSERT_IMP(a_z_zero, clk, rst_n, z_valid && z_zero, z_cos == '0, "zero z axis with nonzero cosines")
    `BDC_ASSERT_NXT(a_dl_hold, clk, rst_n, out_valid_reg && !out_ready, $stable(dl_reg[DLY-1]), "delay line moved during stall")

endmodule

// ===== test/bdc_checker.sv =====
// Scoreboard for beam_direction_cosines_top: predicts each result word from the
// accepted input words and compares it field by field. Depends on bdc_pkg.
module bdc_checker
    import bdc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_word_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_word_t out_data,
    output int        errors,
    output int        pending,
    output int        words_seen,
    output int        degenerate_seen
);
    typedef longint vec3_t [3];

    out_word_t cosines_due[$];

    function automatic bit [63:0] root_floor(input bit [63:0] val);
        bit [63:0] rem;
        bit [63:0] res;
        bit [63:0] pos;
        rem = val;
        res = 0;
        pos = 64'd1 << 62;
        while (pos > rem)
            pos = pos >> 2;
        while (pos != 0)
        begin
            if (rem >= res + pos)
            begin
                rem = rem - (res + pos);
                res = (res >> 1) + pos;
            end
            else
                res = res >> 1;
            pos = pos >> 2;
        end
        return res;
    endfunction

    // returns 1 on a zero vector
    function automatic bit to_unit(input vec3_t v, output vec3_t q);
        bit [63:0] mag [3];
        bit        neg [3];
        bit [63:0] peak;
        bit [63:0] sum;
        bit [63:0] len;
        bit [63:0] c;
        peak = 0;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = v[i] < 0;
            mag[i] = neg[i] ? -v[i] : v[i];
            if (mag[i] > peak)
                peak = mag[i];
        end
        if (peak == 0)
        begin
            q[0] = 0;
            q[1] = 0;
            q[2] = 0;
            return 1'b1;
        end
        while (peak >= (64'd1 << 30))
        begin
            for (int i = 0; i < 3; i++)
                mag[i] = mag[i] >> 1;
            peak = peak >> 1;
        end
        while (peak < (64'd1 << 29))
        begin
            for (int i = 0; i < 3; i++)
                mag[i] = mag[i] << 1;
            peak = peak << 1;
        end
        for (int i = 0; i < 3; i++)
            sum = sum + mag[i] * mag[i];
        len = root_floor(sum);
        for (int i = 0; i < 3; i++)
        begin
            c = ((mag[i] << COS_FRAC_BITS_DEF) + (len >> 1)) / len;
            q[i] = neg[i] ? -longint'(c) : longint'(c);
        end
        return 1'b0;
    endfunction

    function automatic out_word_t beam_frame(input in_word_t w);
        vec3_t span;
        vec3_t nrm;
        vec3_t cr;
        vec3_t ux;
        vec3_t uy;
        vec3_t uz;
        bit    deg;
        out_word_t r;
        span[0] = longint'(w.end_x) - longint'(w.start_x);
        span[1] = longint'(w.end_y) - longint'(w.start_y);
        span[2] = longint'(w.end_z) - longint'(w.start_z);
        nrm[0] = longint'(w.normal_x);
        nrm[1] = longint'(w.normal_y);
        nrm[2] = longint'(w.normal_z);
        deg = to_unit(span, ux);
        deg = to_unit(nrm, uy) | deg;
        cr[0] = ux[1] * uy[2] - ux[2] * uy[1];
        cr[1] = ux[2] * uy[0] - ux[0] * uy[2];
        cr[2] = ux[0] * uy[1] - ux[1] * uy[0];
        deg = to_unit(cr, uz) | deg;
        r.axis_x_0 = ux[0][15:0];
        r.axis_x_1 = ux[1][15:0];
        r.axis_x_2 = ux[2][15:0];
        r.axis_y_0 = uy[0][15:0];
        r.axis_y_1 = uy[1][15:0];
        r.axis_y_2 = uy[2][15:0];
        r.axis_z_0 = uz[0][15:0];
        r.axis_z_1 = uz[1][15:0];
        r.axis_z_2 = uz[2][15:0];
        r.degenerate = deg;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        bit        bad;
        if (!rst_n)
        begin
            errors <= 0;
            pending <= 0;
            words_seen <= 0;
            degenerate_seen <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                cosines_due.push_back(beam_frame(in_data));
            if (out_valid && out_ready)
            begin
                words_seen <= words_seen + 1;
                if (out_data.degenerate)
                    degenerate_seen <= degenerate_seen + 1;
                if (cosines_due.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected result word %h", out_data);
                    errors <= errors + 1;
                end
                else
                begin
                    want = cosines_due.pop_front();
                    bad = 0;
                    // nine cosines, 16 bits each from the top, then the flag
                    for (int k = 0; k < 9; k++)
                        if (out_data[144 - 16 * k -: 16] !== want[144 - 16 * k -: 16])
                            bad = 1;
                    if (out_data.degenerate !== want.degenerate)
                        bad = 1;
                    if (bad)
                    begin
                        if (errors < 10)
                        begin
                            for (int k = 0; k < 9; k++)
                                if (out_data[144 - 16 * k -: 16] !== want[144 - 16 * k -: 16])
                                    $display("cosine %0d: expected %0d got %0d", k,
                                             $signed(want[144 - 16 * k -: 16]),
                                             $signed(out_data[144 - 16 * k -: 16]));
                            if (out_data.degenerate !== want.degenerate)
                                $display("degenerate: expected %b got %b",
                                         want.degenerate, out_data.degenerate);
                        end
                        errors <= errors + 1;
                    end
                end
            end
            pending <= cosines_due.size();
        end
    end
endmodule

// ===== test/beam_direction_cosines_top_tb.sv =====
// Stimulus and verdict for beam_direction_cosines_top; bdc_checker does the
// prediction. Depends on bdc_pkg, bdc_checker and the block itself.
module beam_direction_cosines_top_tb;
    import bdc_pkg::*;

    localparam int WATCHDOG = 20000;

    logic      clk = 0;
    logic      rst_n = 0;
    logic      in_valid = 0;
    logic      in_ready;
    in_word_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 0;
    out_word_t out_data;
    logic      in_taken = 0;
    int        errors;
    int        pending;
    int        words_seen;
    int        degenerate_seen;
    int        send_idle_pct = 19;
    int        recv_stall_pct = 81;
    int        quiet_cycles = 0;
    int        sent = 0;

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    beam_direction_cosines_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    bdc_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .errors(errors), .pending(pending),
        .words_seen(words_seen), .degenerate_seen(degenerate_seen)
    );

    always @(negedge clk)
        out_ready <= $urandom_range(99) >= recv_stall_pct;

    // handshake as seen at the rising edge, read back at the next falling edge
    always @(posedge clk)
        in_taken <= in_valid && in_ready;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("watchdog: no traffic for %0d cycles", WATCHDOG);
            $display("FAIL beam_direction_cosines_top");
            $finish;
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic push_word(input in_word_t w);
        in_data = w;
        in_valid = 1;
        do
            @(negedge clk);
        while (!in_taken);
        sent++;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 0;
            repeat ($urandom_range(4, 1)) @(negedge clk);
        end
    endtask

    task automatic drain();
        in_valid = 0;
        while (pending != 0 || (in_valid && !in_ready))
            @(negedge clk);
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(5))
            0:       return $urandom;
            1:       return $urandom_range(2000) - 1000;
            2:       return 32'h7fffffff - $urandom_range(3);
            3:       return 32'h80000000 + $urandom_range(3);
            4:       return $urandom_range(1) ? 32'sd65536 : -32'sd65536;
            default: return $signed($urandom) >>> $urandom_range(31);
        endcase
    endfunction

    function automatic in_word_t random_beam();
        in_word_t w;
        int       s;
        w.start_x = pick_coord();
        w.start_y = pick_coord();
        w.start_z = pick_coord();
        w.end_x = pick_coord();
        w.end_y = pick_coord();
        w.end_z = pick_coord();
        w.normal_x = pick_coord();
        w.normal_y = pick_coord();
        w.normal_z = pick_coord();
        case ($urandom_range(9))
            0:
            begin
                w.end_x = w.start_x;
                w.end_y = w.start_y;
                w.end_z = w.start_z;
            end
            1:
            begin
                w.normal_x = 0;
                w.normal_y = 0;
                w.normal_z = 0;
            end
            2:
            begin
                // normal parallel to the span
                s = $urandom_range(7) - 3;
                w.start_x = $urandom_range(4000) - 2000;
                w.start_y = $urandom_range(4000) - 2000;
                w.start_z = $urandom_range(4000) - 2000;
                w.end_x = $urandom_range(4000) - 2000;
                w.end_y = $urandom_range(4000) - 2000;
                w.end_z = $urandom_range(4000) - 2000;
                w.normal_x = (w.end_x - w.start_x) * s;
                w.normal_y = (w.end_y - w.start_y) * s;
                w.normal_z = (w.end_z - w.start_z) * s;
            end
            default:;
        endcase
        return w;
    endfunction

    function automatic in_word_t beam_of(input logic [31:0] sx, sy, sz, ex, ey, ez,
                                         nx, ny, nz);
        in_word_t w;
        w.start_x = sx;
        w.start_y = sy;
        w.start_z = sz;
        w.end_x = ex;
        w.end_y = ey;
        w.end_z = ez;
        w.normal_x = nx;
        w.normal_y = ny;
        w.normal_z = nz;
        return w;
    endfunction

    localparam logic [31:0] ONE = 32'h00010000;
    localparam logic [31:0] MAXC = 32'h7fffffff;
    localparam logic [31:0] MINC = 32'h80000000;

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: axis frames, zero vectors, parallel normal, extremes
        push_word(beam_of(0, 0, 0, ONE, 0, 0, 0, ONE, 0));
        push_word(beam_of(0, 0, 0, 0, ONE, 0, 0, 0, ONE));
        push_word(beam_of(0, 0, 0, 0, 0, -ONE, -ONE, 0, 0));
        push_word(beam_of(5, 5, 5, 5, 5, 5, 0, ONE, 0));
        push_word(beam_of(0, 0, 0, ONE, 0, 0, 0, 0, 0));
        push_word(beam_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
        push_word(beam_of(0, 0, 0, ONE, ONE, 0, 2 * ONE, 2 * ONE, 0));
        push_word(beam_of(MINC, MINC, MINC, MAXC, MAXC, MAXC, MINC, 0, MAXC));
        push_word(beam_of(MAXC, MAXC, MAXC, MINC, MINC, MINC, MAXC, MINC, 0));
        push_word(beam_of(MAXC, 0, 0, MINC, 0, 0, 0, MINC, 0));
        push_word(beam_of(0, 0, 0, 1, 0, 0, 0, 0, 1));
        push_word(beam_of(0, 0, 0, 1, 1, 1, 1, -1, 0));
        push_word(beam_of(0, 0, 0, -1, -1, -1, -1, -1, -1));
        push_word(beam_of(0, 0, 0, ONE, ONE, ONE, MAXC, MAXC, MAXC));
        push_word(beam_of(0, 0, 0, 3, 4, 0, 0, 0, MINC));
        push_word(beam_of(32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0,
                          32'hffffffff, 32'hffffffff, 32'hffffffff));
        push_word(beam_of(0, 0, 0, 7, 1, 0, 1, 7, 0));
        push_word(beam_of(0, 0, 0, MAXC, MAXC, 1, 1, MINC, 3));

        repeat (150) push_word(random_beam());
        drain();    // sender holds off until everything is back
        send_idle_pct = 81;
        recv_stall_pct = 19;
        repeat (150) push_word(random_beam());
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (150) push_word(random_beam());
        drain();
        repeat (120) @(negedge clk);

        $display("sent %0d beam words, got %0d frames back, %0d flagged degenerate",
                 sent, words_seen, degenerate_seen);
        $display("covered axis, zero-length, parallel and extreme-coordinate beams");
        if (errors == 0 && pending == 0)
            $display("PASS beam_direction_cosines_top");
        else
            $display("FAIL beam_direction_cosines_top");
        $finish;
    end
endmodule

// ===== beam_direction_cosines_top.f =====
+incdir+design
design/bdc_pkg.sv
design/bdc_unit_vec.sv
design/beam_direction_cosines_top.sv
test/bdc_checker.sv
test/beam_direction_cosines_top_tb.sv
